// File: hw/rtl/wsm_pkg.sv
// ---------------------------------------------------------------------------
// wsm_pkg
// Shared types and constants for the word stack machine.
// ---------------------------------------------------------------------------
package wsm_pkg;

	localparam int DATA_W          = 32;
	localparam int FUNC_W          = 3;
	localparam int STATUS_W        = 2;
	localparam int DEPTH_W         = 7;
	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DUP  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] push_value;
	} cmd_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   top_value;
		logic [DEPTH_W-1:0]  depth;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ARITH,
		S_LOAD_TOP
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_PUSH,
		CMD_DUP,
		CMD_POP_RD,
		CMD_ARG_RD,
		CMD_ARITH_OK,
		CMD_ARITH_ERR,
		CMD_LOAD_TOP
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t             cmd;
		logic                sub;
		logic                finish;
		logic [STATUS_W-1:0] status;
	} dp_ctl_t;

	typedef struct packed {
		logic empty;
		logic few;
		logic full;
		logic ge3;
		logic arith_err;
	} dp_stat_t;

endpackage

// File: hw/rtl/wsm_ram.sv
// ---------------------------------------------------------------------------
// wsm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module wsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/wsm_ctrl.sv
// ---------------------------------------------------------------------------
// wsm_ctrl
// Controller: decodes each word and sequences the datapath.
// ---------------------------------------------------------------------------
module wsm_ctrl import wsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  dp_stat_t          stat,
	output dp_ctl_t           ctl,
	output logic              busy
);

	state_t              state_q, state_d;
	logic                sub_q, sub_d;
	logic [STATUS_W-1:0] status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sub_q    <= 1'b0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			sub_q    <= sub_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		sub_d      = sub_q;
		status_d   = status_q;
		ctl.cmd    = CMD_NONE;
		ctl.sub    = sub_q;
		ctl.finish = 1'b0;
		ctl.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_PUSH: begin
							ctl.finish = 1'b1;
							if (stat.full) begin
								ctl.status = ST_FULL;
							end else begin
								ctl.cmd = CMD_PUSH;
							end
						end
						FUNC_ADD, FUNC_SUB: begin
							if (stat.few) begin
								ctl.finish = 1'b1;
								ctl.status = ST_FEW;
							end else begin
								ctl.cmd = CMD_ARG_RD;
								sub_d   = (func == FUNC_SUB);
								state_d = S_ARITH;
							end
						end
						FUNC_POP: begin
							if (stat.empty) begin
								ctl.finish = 1'b1;
								ctl.status = ST_FEW;
							end else begin
								ctl.cmd = CMD_POP_RD;
								if (stat.few) begin
									ctl.finish = 1'b1;
								end else begin
									status_d = ST_OK;
									state_d  = S_LOAD_TOP;
								end
							end
						end
						FUNC_DUP: begin
							ctl.finish = 1'b1;
							if (stat.empty) begin
								ctl.status = ST_FEW;
							end else if (stat.full) begin
								ctl.status = ST_FULL;
							end else begin
								ctl.cmd = CMD_DUP;
							end
						end
						default: begin
							ctl.finish = 1'b1;
						end
					endcase
				end
			end
			S_ARITH: begin
				if (stat.arith_err) begin
					ctl.cmd = CMD_ARITH_ERR;
					if (stat.ge3) begin
						status_d = ST_RANGE;
						state_d  = S_LOAD_TOP;
					end else begin
						ctl.finish = 1'b1;
						ctl.status = ST_RANGE;
						state_d    = S_IDLE;
					end
				end else begin
					ctl.cmd    = CMD_ARITH_OK;
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_LOAD_TOP: begin
				ctl.cmd    = CMD_LOAD_TOP;
				ctl.finish = 1'b1;
				ctl.status = status_q;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/wsm_dp.sv
// ---------------------------------------------------------------------------
// wsm_dp
// Datapath: cached top of stack, entry count, stack RAM, adder and result.
// ---------------------------------------------------------------------------
module wsm_dp import wsm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DATA_W-1:0] push_value,
	input  dp_ctl_t           ctl,
	output dp_stat_t          stat,
	output logic              done,
	output result_t           result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [CW-1:0]     count_q, count_d;
	logic [DATA_W-1:0] top_q, top_d;
	logic              done_q;
	result_t           result_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] rdata;
	logic [CW-1:0]     cnt_m1, cnt_m2, cnt_m3;
	logic [DATA_W:0]   sum;
	logic              borrow;

	wsm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(top_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign cnt_m3 = count_q - CW'(3);

	assign sum    = {1'b0, top_q} + {1'b0, rdata};
	assign borrow = (rdata < top_q);

	assign stat.empty     = (count_q == '0);
	assign stat.few       = (count_q < CW'(2));
	assign stat.full      = (count_q >= CW'(STACK_DEPTH));
	assign stat.ge3       = (count_q >= CW'(3));
	assign stat.arith_err = ctl.sub ? borrow : sum[DATA_W];

	always_comb begin
		count_d = count_q;
		top_d   = top_q;
		we      = 1'b0;
		waddr   = cnt_m1[AW-1:0];
		raddr   = cnt_m2[AW-1:0];
		case (ctl.cmd)
			CMD_PUSH: begin
				we      = !stat.empty;
				top_d   = push_value;
				count_d = count_q + CW'(1);
			end
			CMD_DUP: begin
				we      = 1'b1;
				count_d = count_q + CW'(1);
			end
			CMD_POP_RD: begin
				count_d = cnt_m1;
			end
			CMD_ARG_RD: begin
			end
			CMD_ARITH_OK: begin
				top_d   = ctl.sub ? (rdata - top_q) : sum[DATA_W-1:0];
				count_d = cnt_m1;
			end
			CMD_ARITH_ERR: begin
				raddr   = cnt_m3[AW-1:0];
				count_d = cnt_m2;
			end
			CMD_LOAD_TOP: begin
				top_d = rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (ctl.finish) begin
			result_q.status    <= ctl.status;
			result_q.top_value <= (count_d == '0) ? '0 : top_d;
			result_q.depth     <= DEPTH_W'(count_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hw/rtl/word_stack_machine.sv
// ---------------------------------------------------------------------------
// word_stack_machine
// Stack calculator on unsigned 32-bit values: push, add, subtract, pop, dup.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its result appears on
// result for exactly one cycle with done high, in the cycle after the word's
// last controller state; the receiver cannot stall it. Push, dup, unknown
// words and every rejected word are finished on acceptance (result in the
// cycle after acceptance). Pop with two or more entries goes on to S_LOAD_TOP;
// add or subtract goes on to S_ARITH, and on overflow or underflow with three
// or more entries then to S_LOAD_TOP. These states await the registered read
// of the stack RAM (one write port, one read port) for the second entry or the
// new top; the top entry is cached in a register. No clearing pass after reset.
// ---------------------------------------------------------------------------
module word_stack_machine import wsm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_word_t word,
	output logic      done,
	output result_t   result
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	wsm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (word.func),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy)
	);

	wsm_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_value(word.push_value),
		.ctl       (ctl),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule
